// ===== rtl/lrbb_pkg.sv =====
// Shared types, constants and helper functions of the lit region bounding box block.
package lrbb_pkg;

   // Coordinate width and sampling grid pitch.
   localparam int COORD_BITS    = 12;
   localparam int SAMPLE_STRIDE = 4;

   // Fixed field widths.
   localparam int COLOR_BITS  = 8;
   localparam int THR_BITS    = 10;
   localparam int HIT_BITS    = 21;
   localparam int SIZE_BITS   = 13;
   localparam int SUM_BITS    = COLOR_BITS + 2;

   // Signed width that holds every box bound, including the frame size and minus one.
   localparam int BOX_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 6 * COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 4 * COORD_BITS + HIT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] CSR_IDX_DIFF_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_IDX_MIN_HITS       = 2'd1;
   localparam logic [1:0] CSR_IDX_FRAME_WIDTH    = 2'd2;
   localparam logic [1:0] CSR_IDX_FRAME_HEIGHT   = 2'd3;

   // Register reset values.
   localparam logic [THR_BITS-1:0]  DIFF_THRESHOLD_RESET = THR_BITS'(300);
   localparam logic [HIT_BITS-1:0]  MIN_HITS_RESET       = HIT_BITS'(250);
   localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RESET    = SIZE_BITS'(640);
   localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RESET   = SIZE_BITS'(360);

   // Hit counter saturation value.
   localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

   // Division of a frame size by five: (v * 3277) >> 14 is exact for 13-bit v.
   localparam int FIFTH_MUL_BITS = 12;
   localparam int FIFTH_SHIFT    = 14;
   localparam int FIFTH_BITS     = SIZE_BITS - 2;
   localparam logic [FIFTH_MUL_BITS-1:0] FIFTH_MUL = FIFTH_MUL_BITS'(3277);

   // Grid test constants: v is a multiple of the stride when the low GRID_SHIFT
   // bits of v * GRID_MUL fall below GRID_MUL.
   localparam int GRID_SHIFT = COORD_BITS + 4;
   localparam logic [GRID_SHIFT:0] GRID_MUL =
      (GRID_SHIFT + 1)'((2 ** GRID_SHIFT + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE);

   // One accepted pixel pair after the threshold test.
   typedef struct packed {
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic                  hit;
      logic                  last;
   } lrbb_item_type;

   // Running bounding box and hit count of one frame.
   typedef struct packed {
      logic signed [BOX_BITS-1:0] min_col;
      logic signed [BOX_BITS-1:0] min_row;
      logic signed [BOX_BITS-1:0] max_col;
      logic signed [BOX_BITS-1:0] max_row;
      logic [HIT_BITS-1:0]        hits;
   } lrbb_box_type;

   // One result transaction.
   typedef struct packed {
      logic                  found;
      logic [COORD_BITS-1:0] box_left;
      logic [COORD_BITS-1:0] box_top;
      logic [COORD_BITS-1:0] box_right;
      logic [COORD_BITS-1:0] box_bottom;
      logic [HIT_BITS-1:0]   hit_total;
   } lrbb_result_type;

   // True when a coordinate lies on the sampling grid.
   function automatic logic on_grid(logic [COORD_BITS-1:0] v);
      logic [COORD_BITS+GRID_SHIFT:0] prod;
      prod = {{(GRID_SHIFT + 1){1'b0}}, v} * {{COORD_BITS{1'b0}}, GRID_MUL};
      return {1'b0, prod[GRID_SHIFT-1:0]} < GRID_MUL;
   endfunction

endpackage

// ===== rtl/lrbb_accum.sv =====
// Running bounding box and hit counter that one frame builds up.
module lrbb_accum (
   input  logic                            clock,
   input  logic                            reset,
   input  lrbb_pkg::lrbb_item_type         item,
   input  logic                            take,
   input  logic [lrbb_pkg::SIZE_BITS-1:0]  frame_width,
   input  logic [lrbb_pkg::SIZE_BITS-1:0]  frame_height,
   output lrbb_pkg::lrbb_box_type          box_next
);

   lrbb_pkg::lrbb_box_type box_ff;
   lrbb_pkg::lrbb_box_type box_in;
   lrbb_pkg::lrbb_box_type box_clear;
   logic signed [lrbb_pkg::BOX_BITS-1:0] col;
   logic signed [lrbb_pkg::BOX_BITS-1:0] row;

   // Coordinates widened to the signed box width.
   assign col = $signed({{(lrbb_pkg::BOX_BITS - lrbb_pkg::COORD_BITS){1'b0}}, item.pos_x});
   assign row = $signed({{(lrbb_pkg::BOX_BITS - lrbb_pkg::COORD_BITS){1'b0}}, item.pos_y});

   // Empty box for the next frame, seeded from the current frame size.
   always_comb begin
      box_clear.min_col = $signed({{(lrbb_pkg::BOX_BITS - lrbb_pkg::SIZE_BITS){1'b0}},
                                   frame_width});
      box_clear.min_row = $signed({{(lrbb_pkg::BOX_BITS - lrbb_pkg::SIZE_BITS){1'b0}},
                                   frame_height});
      box_clear.max_col = '1;
      box_clear.max_row = '1;
      box_clear.hits    = '0;
   end

   // A hit widens the box and bumps the saturating counter.
   always_comb begin
      box_next = box_ff;
      if (item.hit) begin
         if (col < box_ff.min_col) box_next.min_col = col;
         if (row < box_ff.min_row) box_next.min_row = row;
         if (col > box_ff.max_col) box_next.max_col = col;
         if (row > box_ff.max_row) box_next.max_row = row;
         if (box_ff.hits != lrbb_pkg::HIT_MAX) begin
            box_next.hits = box_ff.hits + lrbb_pkg::HIT_BITS'(1);
         end
      end
   end

   // The frame-end pixel hands its box on and starts a fresh frame.
   always_comb begin
      box_in = box_ff;
      if (take) begin
         box_in = item.last ? box_clear : box_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.min_col <= $signed({{(lrbb_pkg::BOX_BITS - lrbb_pkg::SIZE_BITS){1'b0}},
                                    lrbb_pkg::FRAME_WIDTH_RESET});
         box_ff.min_row <= $signed({{(lrbb_pkg::BOX_BITS - lrbb_pkg::SIZE_BITS){1'b0}},
                                    lrbb_pkg::FRAME_HEIGHT_RESET});
         box_ff.max_col <= '1;
         box_ff.max_row <= '1;
         box_ff.hits    <= '0;
      end else begin
         box_ff <= box_in;
      end
   end

endmodule

// ===== rtl/lrbb_eval.sv =====
// End-of-frame check of a finished box: hit count, minimum size and clipping.
module lrbb_eval (
   input  lrbb_pkg::lrbb_box_type           box,
   input  logic [lrbb_pkg::HIT_BITS-1:0]    min_hits,
   input  logic [lrbb_pkg::SIZE_BITS-1:0]   frame_width,
   input  logic [lrbb_pkg::SIZE_BITS-1:0]   frame_height,
   input  logic [lrbb_pkg::FIFTH_BITS-1:0]  fifth_width,
   input  logic [lrbb_pkg::FIFTH_BITS-1:0]  fifth_height,
   output lrbb_pkg::lrbb_result_type        result
);

   localparam int EB = lrbb_pkg::BOX_BITS + 1;
   localparam logic signed [EB-1:0] ONE = EB'(1);

   logic signed [EB-1:0] left, top, right, bottom;
   logic signed [EB-1:0] span_x, span_y;
   logic signed [EB-1:0] last_col, last_row;
   logic signed [EB-1:0] right_clip, bottom_clip;
   logic signed [EB-1:0] need_x, need_y;
   logic                 ok;

   // Widen the bounds so that the span cannot overflow.
   assign left   = {box.min_col[lrbb_pkg::BOX_BITS-1], box.min_col};
   assign top    = {box.min_row[lrbb_pkg::BOX_BITS-1], box.min_row};
   assign right  = {box.max_col[lrbb_pkg::BOX_BITS-1], box.max_col};
   assign bottom = {box.max_row[lrbb_pkg::BOX_BITS-1], box.max_row};

   assign span_x = right - left + ONE;
   assign span_y = bottom - top + ONE;

   assign need_x = $signed({{(EB - lrbb_pkg::FIFTH_BITS){1'b0}}, fifth_width});
   assign need_y = $signed({{(EB - lrbb_pkg::FIFTH_BITS){1'b0}}, fifth_height});

   // Clip the far edges to the frame; the near edges are never negative.
   assign last_col    = $signed({{(EB - lrbb_pkg::SIZE_BITS){1'b0}}, frame_width}) - ONE;
   assign last_row    = $signed({{(EB - lrbb_pkg::SIZE_BITS){1'b0}}, frame_height}) - ONE;
   assign right_clip  = (right > last_col) ? last_col : right;
   assign bottom_clip = (bottom > last_row) ? last_row : bottom;

   assign ok = (box.hits >= min_hits) && (span_x >= need_x) && (span_y >= need_y) &&
               (left <= right_clip) && (top <= bottom_clip);

   // The box reads zero when no region is found; the count is always given.
   always_comb begin
      result.found      = ok;
      result.box_left   = ok ? left[lrbb_pkg::COORD_BITS-1:0] : '0;
      result.box_top    = ok ? top[lrbb_pkg::COORD_BITS-1:0] : '0;
      result.box_right  = ok ? right_clip[lrbb_pkg::COORD_BITS-1:0] : '0;
      result.box_bottom = ok ? bottom_clip[lrbb_pkg::COORD_BITS-1:0] : '0;
      result.hit_total  = box.hits;
   end

endmodule

// ===== rtl/lit_region_bounding_box_top.sv =====
// Top level of the lit region bounding box block: stream ports, registers and pipeline control.
//
// The block takes one pixel pair per clock cycle, except while a frame-end pair is held,
// and returns one result transaction for each pair marked with tlast. That pair passes the
// input register, where the threshold and grid tests are made, then the running box and
// frame snapshot register, and then the output register, where the size and clipping
// checks are made. Pairs that do not end a frame keep flowing while a result
// waits at the output; a frame-end pair is held in the input register only while both the
// snapshot and the output register still hold results of earlier frames. Register writes
// take effect at once and are meant to be made between frames.
module lit_region_bounding_box_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // Pixel pair stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata from bit 0 up: pos_x, pos_y, dark_red, dark_green, dark_blue,
   // lit_red, lit_green, lit_blue.
   input  logic [lrbb_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tlast,
   // Result stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata from bit 0 up: box_left, box_top, box_right, box_bottom, hit_total, zero pad.
   output logic [lrbb_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // tuser: found.
   output logic                                 rsp_tuser,
   // Configuration port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lrbb_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lrbb_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lrbb_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int CB = lrbb_pkg::COORD_BITS;
   localparam int KB = lrbb_pkg::COLOR_BITS;
   localparam int SB = lrbb_pkg::SUM_BITS;

   // Configuration registers.
   logic [lrbb_pkg::THR_BITS-1:0]   diff_threshold_ff;
   logic [lrbb_pkg::HIT_BITS-1:0]   min_hits_ff;
   logic [lrbb_pkg::SIZE_BITS-1:0]  frame_width_ff;
   logic [lrbb_pkg::SIZE_BITS-1:0]  frame_height_ff;
   logic [lrbb_pkg::FIFTH_BITS-1:0] fifth_width_ff, fifth_width_in;
   logic [lrbb_pkg::FIFTH_BITS-1:0] fifth_height_ff, fifth_height_in;
   logic [lrbb_pkg::SIZE_BITS+lrbb_pkg::FIFTH_MUL_BITS-1:0] fifth_width_prod;
   logic [lrbb_pkg::SIZE_BITS+lrbb_pkg::FIFTH_MUL_BITS-1:0] fifth_height_prod;
   logic       csr_write;
   logic [1:0] csr_index;

   // Pipeline registers and control.
   logic                      a_valid_ff, a_valid_in;
   lrbb_pkg::lrbb_item_type   a_item_ff, a_item_in;
   logic                      snap_valid_ff, snap_valid_in;
   lrbb_pkg::lrbb_box_type    snap_ff;
   lrbb_pkg::lrbb_box_type    box_next;
   logic                      rsp_valid_ff, rsp_valid_in;
   lrbb_pkg::lrbb_result_type rsp_ff;
   lrbb_pkg::lrbb_result_type eval_result;
   logic                      out_free, snap_move, snap_free, a_take, req_fire;

   // Input tests.
   logic [CB-1:0] in_x, in_y;
   logic [SB-1:0] dark_sum, lit_sum;
   logic [SB:0]   dark_plus_thr;

   // ---------------------------------------------------------------------
   // Configuration port: writes in the access phase, reads are combinational.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_threshold_ff <= lrbb_pkg::DIFF_THRESHOLD_RESET;
         min_hits_ff       <= lrbb_pkg::MIN_HITS_RESET;
         frame_width_ff    <= lrbb_pkg::FRAME_WIDTH_RESET;
         frame_height_ff   <= lrbb_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lrbb_pkg::CSR_IDX_DIFF_THRESHOLD: begin
               diff_threshold_ff <= csr_pwdata[lrbb_pkg::THR_BITS-1:0];
            end
            lrbb_pkg::CSR_IDX_MIN_HITS: begin
               min_hits_ff <= csr_pwdata[lrbb_pkg::HIT_BITS-1:0];
            end
            lrbb_pkg::CSR_IDX_FRAME_WIDTH: begin
               frame_width_ff <= csr_pwdata[lrbb_pkg::SIZE_BITS-1:0];
            end
            lrbb_pkg::CSR_IDX_FRAME_HEIGHT: begin
               frame_height_ff <= csr_pwdata[lrbb_pkg::SIZE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         lrbb_pkg::CSR_IDX_DIFF_THRESHOLD: begin
            csr_prdata = lrbb_pkg::CSR_DATA_BITS'(diff_threshold_ff);
         end
         lrbb_pkg::CSR_IDX_MIN_HITS: begin
            csr_prdata = lrbb_pkg::CSR_DATA_BITS'(min_hits_ff);
         end
         lrbb_pkg::CSR_IDX_FRAME_WIDTH: begin
            csr_prdata = lrbb_pkg::CSR_DATA_BITS'(frame_width_ff);
         end
         lrbb_pkg::CSR_IDX_FRAME_HEIGHT: begin
            csr_prdata = lrbb_pkg::CSR_DATA_BITS'(frame_height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // One fifth of the frame size, kept registered for the size check.
   assign fifth_width_prod  = {{lrbb_pkg::FIFTH_MUL_BITS{1'b0}}, frame_width_ff} *
                              {{lrbb_pkg::SIZE_BITS{1'b0}}, lrbb_pkg::FIFTH_MUL};
   assign fifth_height_prod = {{lrbb_pkg::FIFTH_MUL_BITS{1'b0}}, frame_height_ff} *
                              {{lrbb_pkg::SIZE_BITS{1'b0}}, lrbb_pkg::FIFTH_MUL};
   assign fifth_width_in  = fifth_width_prod[lrbb_pkg::FIFTH_SHIFT +: lrbb_pkg::FIFTH_BITS];
   assign fifth_height_in = fifth_height_prod[lrbb_pkg::FIFTH_SHIFT +: lrbb_pkg::FIFTH_BITS];

   always_ff @(posedge clock) begin
      fifth_width_ff  <= fifth_width_in;
      fifth_height_ff <= fifth_height_in;
   end

   // ---------------------------------------------------------------------
   // Input stage: grid and threshold tests on the incoming pair.
   // ---------------------------------------------------------------------
   assign in_x = req_tdata[CB-1:0];
   assign in_y = req_tdata[2*CB-1:CB];

   assign dark_sum = SB'(req_tdata[2*CB +: KB]) + SB'(req_tdata[2*CB+KB +: KB]) +
                     SB'(req_tdata[2*CB+2*KB +: KB]);
   assign lit_sum  = SB'(req_tdata[2*CB+3*KB +: KB]) + SB'(req_tdata[2*CB+4*KB +: KB]) +
                     SB'(req_tdata[2*CB+5*KB +: KB]);
   assign dark_plus_thr = {1'b0, dark_sum} + (SB + 1)'(diff_threshold_ff);

   always_comb begin
      a_item_in.pos_x = in_x;
      a_item_in.pos_y = in_y;
      a_item_in.hit   = lrbb_pkg::on_grid(in_x) && lrbb_pkg::on_grid(in_y) &&
                        ({1'b0, lit_sum} > dark_plus_thr);
      a_item_in.last  = req_tlast;
   end

   // ---------------------------------------------------------------------
   // Flow control: only a frame-end pair can wait, and only for the snapshot.
   // ---------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign snap_move  = snap_valid_ff && out_free;
   assign snap_free  = !snap_valid_ff || out_free;
   assign a_take     = a_valid_ff && (!a_item_ff.last || snap_free);
   assign req_tready = !a_valid_ff || a_take;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_take) begin
         a_valid_in = 1'b0;
      end

      snap_valid_in = snap_valid_ff;
      if (a_take && a_item_ff.last) begin
         snap_valid_in = 1'b1;
      end else if (snap_move) begin
         snap_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (snap_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers load only on their stage's transfer.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_item_ff <= a_item_in;
      end
      if (a_take && a_item_ff.last) begin
         snap_ff <= box_next;
      end
      if (snap_move) begin
         rsp_ff <= eval_result;
      end
   end

   // ---------------------------------------------------------------------
   // Running box and end-of-frame evaluation.
   // ---------------------------------------------------------------------
   lrbb_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .item         (a_item_ff),
      .take         (a_take),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .box_next     (box_next)
   );

   lrbb_eval u_eval (
      .box          (snap_ff),
      .min_hits     (min_hits_ff),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .fifth_width  (fifth_width_ff),
      .fifth_height (fifth_height_ff),
      .result       (eval_result)
   );

   // Result stream outputs.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.found;
   assign rsp_tdata  = {{(lrbb_pkg::RSP_DATA_BITS - lrbb_pkg::RSP_FIELD_BITS){1'b0}},
                        rsp_ff.hit_total, rsp_ff.box_bottom, rsp_ff.box_right,
                        rsp_ff.box_top, rsp_ff.box_left};

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // A frame-end pair held back keeps its contents until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_take) |=> (a_valid_ff && $stable(a_item_ff)))
      else $error("held input transaction changed or was dropped");

   // A found region is a proper box.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |->
         ((rsp_ff.box_left <= rsp_ff.box_right) && (rsp_ff.box_top <= rsp_ff.box_bottom)))
      else $error("found region has inverted bounds");

   // A found region has at least the required number of hits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> (rsp_ff.hit_total >= min_hits_ff))
      else $error("found region with too few hits");

endmodule
